>>> rtl/core/wsh_pkg.sv
// shared types, constants and mix functions for the word stream lookup3 hash
// no dependencies
`default_nettype none

package wsh_pkg;

    localparam int unsigned WORD_W    = 32;
    localparam int unsigned LEN_W     = 16;
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int unsigned QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    localparam logic [WORD_W-1:0] HASH_INIT = 32'hdeadbeef;

    // which accumulator takes the next word
    typedef enum logic [1:0] {
        POS_A = 2'd0,
        POS_B = 2'd1,
        POS_C = 2'd2
    } t_pos;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_MIX   = 2'd1,
        ST_FINAL = 2'd2
    } t_state;

    typedef struct packed {
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
        logic [WORD_W-1:0] c;
    } t_abc;

    // one classified item, front to back
    typedef struct packed {
        logic [WORD_W-1:0] init_val;
        logic [WORD_W-1:0] word;
        logic              load_init;
        logic              has_word;
        t_pos              sel;
        logic              do_mix;
        logic              do_final;
        logic              emit;
    } t_cmd;

    function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] x,
                                               input int unsigned k);
        return (x << k) | (x >> (WORD_W - k));
    endfunction

    // three of the six rounds of the triple mix, first or second half
    function automatic t_abc mix_half(input t_abc s, input logic step);
        t_abc t;
        t = s;
        if (!step) begin
            t.a = t.a - t.c; t.a = t.a ^ rotl(t.c, 4);  t.c = t.c + t.b;
            t.b = t.b - t.a; t.b = t.b ^ rotl(t.a, 6);  t.a = t.a + t.c;
            t.c = t.c - t.b; t.c = t.c ^ rotl(t.b, 8);  t.b = t.b + t.a;
        end else begin
            t.a = t.a - t.c; t.a = t.a ^ rotl(t.c, 16); t.c = t.c + t.b;
            t.b = t.b - t.a; t.b = t.b ^ rotl(t.a, 19); t.a = t.a + t.c;
            t.c = t.c - t.b; t.c = t.c ^ rotl(t.b, 4);  t.b = t.b + t.a;
        end
        return t;
    endfunction

    // final mix in three steps: three rounds, three rounds, one round
    function automatic t_abc final_third(input t_abc s, input logic [1:0] step);
        t_abc t;
        t = s;
        case (step)
            2'd0: begin
                t.c = t.c ^ t.b; t.c = t.c - rotl(t.b, 14);
                t.a = t.a ^ t.c; t.a = t.a - rotl(t.c, 11);
                t.b = t.b ^ t.a; t.b = t.b - rotl(t.a, 25);
            end
            2'd1: begin
                t.c = t.c ^ t.b; t.c = t.c - rotl(t.b, 16);
                t.a = t.a ^ t.c; t.a = t.a - rotl(t.c, 4);
                t.b = t.b ^ t.a; t.b = t.b - rotl(t.a, 14);
            end
            2'd2: begin
                t.c = t.c ^ t.b; t.c = t.c - rotl(t.b, 24);
            end
            default: begin
                t = s;
            end
        endcase
        return t;
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/wsh_front.sv
// front end: seed register, triple position tracking, item classification
// depends on wsh_pkg
`default_nettype none

module wsh_front (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cfg_we,
    input  wire logic [wsh_pkg::WORD_W-1:0] i_cfg_seed,
    input  wire logic                       i_accept,
    input  wire logic [wsh_pkg::WORD_W-1:0] i_data_word,
    input  wire logic [wsh_pkg::LEN_W-1:0]  i_msg_length,
    input  wire logic                       i_first,
    input  wire logic                       i_last,
    output wsh_pkg::t_cmd                   o_cmd
);

    logic [wsh_pkg::WORD_W-1:0] r_seed;
    wsh_pkg::t_pos              r_pos;
    wsh_pkg::t_pos              n_pos;
    wsh_pkg::t_pos              pos_eff;
    logic                       has_word;
    logic [wsh_pkg::WORD_W-1:0] len_x4;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed <= '0;
            r_pos  <= wsh_pkg::POS_A;
        end else begin
            if (i_cfg_we) begin
                r_seed <= i_cfg_seed;
            end
            if (i_accept) begin
                r_pos <= n_pos;
            end
        end
    end

    // length is 16 bits, always within the word limit
    assign len_x4 = {{(wsh_pkg::WORD_W - wsh_pkg::LEN_W - 2){1'b0}}, i_msg_length, 2'b00};

    always_comb begin
        pos_eff  = i_first ? wsh_pkg::POS_A : r_pos;
        has_word = !(i_first && (i_msg_length == '0));

        if (i_last) begin
            n_pos = wsh_pkg::POS_A;
        end else if (has_word) begin
            unique case (pos_eff)
                wsh_pkg::POS_A: n_pos = wsh_pkg::POS_B;
                wsh_pkg::POS_B: n_pos = wsh_pkg::POS_C;
                default:        n_pos = wsh_pkg::POS_A;
            endcase
        end else begin
            n_pos = pos_eff;
        end

        o_cmd.init_val  = wsh_pkg::HASH_INIT + len_x4 + r_seed;
        o_cmd.word      = i_data_word;
        o_cmd.load_init = i_first;
        o_cmd.has_word  = has_word;
        o_cmd.sel       = pos_eff;
        o_cmd.do_mix    = has_word && !i_last && (pos_eff == wsh_pkg::POS_C);
        o_cmd.do_final  = has_word && i_last;
        o_cmd.emit      = i_last;
    end

endmodule

`default_nettype wire

>>> rtl/core/wsh_fifo.sv
// small show-ahead command queue between front and back
// depends on wsh_pkg
`default_nettype none

module wsh_fifo (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_push,
    input  wire wsh_pkg::t_cmd i_cmd,
    output logic        o_full,
    input  wire logic   i_pop,
    output logic        o_empty,
    output wsh_pkg::t_cmd o_cmd
);

    wsh_pkg::t_cmd                r_mem [wsh_pkg::QUEUE_DEPTH];
    logic [wsh_pkg::QUEUE_AW-1:0] r_wr_ptr;
    logic [wsh_pkg::QUEUE_AW-1:0] r_rd_ptr;
    logic [wsh_pkg::QUEUE_CW-1:0] r_count;
    logic                         do_push;
    logic                         do_pop;

    assign o_full  = (r_count == wsh_pkg::QUEUE_CW'(wsh_pkg::QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_cmd   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= wsh_pkg::QUEUE_CW'(wsh_pkg::QUEUE_DEPTH))
        else $error("queue count beyond depth");

    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) || (r_count == wsh_pkg::QUEUE_CW'(wsh_pkg::QUEUE_DEPTH))
        |-> (r_wr_ptr == r_rd_ptr))
        else $error("queue pointers disagree with count");
`endif

endmodule

`default_nettype wire

>>> rtl/core/wsh_back.sv
// back end: accumulators, word add, mix sequencer and result register
// depends on wsh_pkg
`default_nettype none

module wsh_back (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_q_empty,
    input  wire wsh_pkg::t_cmd              i_cmd,
    output logic                            o_q_pop,
    output logic                            o_empty,
    input  wire logic                       i_pop,
    output logic [wsh_pkg::WORD_W-1:0]      o_hash_value
);

    wsh_pkg::t_state            r_state;
    wsh_pkg::t_state            n_state;
    logic [1:0]                 r_step;
    logic [1:0]                 n_step;
    wsh_pkg::t_abc              r_acc;
    wsh_pkg::t_abc              n_acc;
    logic                       r_out_valid;
    logic                       n_out_valid;
    logic [wsh_pkg::WORD_W-1:0] r_out_hash;
    logic [wsh_pkg::WORD_W-1:0] n_out_hash;
    wsh_pkg::t_abc              loaded;
    wsh_pkg::t_abc              mixed;
    wsh_pkg::t_abc              finaled;
    logic                       slot_free;

    assign o_empty      = !r_out_valid;
    assign o_hash_value = r_out_hash;
    assign slot_free    = !r_out_valid || i_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= wsh_pkg::ST_IDLE;
            r_step      <= '0;
            r_acc       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_acc       <= n_acc;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_hash <= n_out_hash;
    end

    // start value plus the word in its slot
    always_comb begin
        if (i_cmd.load_init) begin
            loaded.a = i_cmd.init_val;
            loaded.b = i_cmd.init_val;
            loaded.c = i_cmd.init_val;
        end else begin
            loaded = r_acc;
        end
        if (i_cmd.has_word) begin
            unique case (i_cmd.sel)
                wsh_pkg::POS_A: loaded.a = loaded.a + i_cmd.word;
                wsh_pkg::POS_B: loaded.b = loaded.b + i_cmd.word;
                default:        loaded.c = loaded.c + i_cmd.word;
            endcase
        end
    end

    assign mixed   = wsh_pkg::mix_half(r_acc, r_step[0]);
    assign finaled = wsh_pkg::final_third(r_acc, r_step);

    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        n_acc       = r_acc;
        n_out_valid = r_out_valid && !i_pop;
        n_out_hash  = r_out_hash;
        o_q_pop     = 1'b0;

        unique case (r_state)
            wsh_pkg::ST_IDLE: begin
                if (!i_q_empty && (!i_cmd.emit || slot_free)) begin
                    o_q_pop = 1'b1;
                    n_acc   = loaded;
                    n_step  = '0;
                    if (i_cmd.do_final) begin
                        n_state = wsh_pkg::ST_FINAL;
                    end else if (i_cmd.do_mix) begin
                        n_state = wsh_pkg::ST_MIX;
                    end else if (i_cmd.emit) begin
                        n_out_valid = 1'b1;
                        n_out_hash  = loaded.c;
                    end
                end
            end
            wsh_pkg::ST_MIX: begin
                n_acc  = mixed;
                n_step = r_step + 1'b1;
                if (r_step[0]) begin
                    n_state = wsh_pkg::ST_IDLE;
                end
            end
            wsh_pkg::ST_FINAL: begin
                n_acc  = finaled;
                n_step = r_step + 1'b1;
                if (r_step == 2'd2) begin
                    n_state     = wsh_pkg::ST_IDLE;
                    n_out_valid = 1'b1;
                    n_out_hash  = finaled.c;
                end
            end
            default: begin
                n_state = wsh_pkg::ST_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_pop_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |-> (r_state == wsh_pkg::ST_IDLE) && !i_q_empty)
        else $error("command taken while busy");

    a_mix_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == wsh_pkg::ST_MIX) |-> (r_step <= 2'd1))
        else $error("mix step out of range");

    a_final_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == wsh_pkg::ST_FINAL) && (r_step == 2'd2) |-> !r_out_valid || i_pop)
        else $error("final hash would overwrite a waiting result");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !i_pop |=> r_out_valid && $stable(r_out_hash))
        else $error("waiting result lost or changed");
`endif

endmodule

`default_nettype wire

>>> rtl/core/word_stream_hash_lookup3.sv
// top level of the streaming lookup3 word hash
// depends on wsh_pkg, wsh_front, wsh_fifo, wsh_back
//
// channel   direction  handshake            payload
// input     in         push / full          i_data_word, i_msg_length, i_first, i_last
// result    out        empty / pop          o_hash_value
// config    in         i_cfg_we (no wait)   i_cfg_seed
//
// flow: the front takes one item per cycle while the command queue has room.
// the back takes one item from the queue when idle; a completed triple that is not
// last then runs the triple mix in halves of three rounds, and a last item with a
// word the final mix in steps of 3+3+1 rounds; no new item is taken meanwhile.
// reset clears seed, accumulators, triple position, queue and the result valid flag.
// a waiting result never blocks input until the four-entry queue fills.
`default_nettype none

module word_stream_hash_lookup3 (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    // configuration
    input  wire logic                       i_cfg_we,
    input  wire logic [wsh_pkg::WORD_W-1:0] i_cfg_seed,
    // input items
    input  wire logic                       push,
    output logic                            full,
    input  wire logic [wsh_pkg::WORD_W-1:0] i_data_word,
    input  wire logic [wsh_pkg::LEN_W-1:0]  i_msg_length,
    input  wire logic                       i_first,
    input  wire logic                       i_last,
    // result items
    output logic                            empty,
    input  wire logic                       pop,
    output logic [wsh_pkg::WORD_W-1:0]      o_hash_value
);

    wsh_pkg::t_cmd front_cmd;   // classified item from the front
    wsh_pkg::t_cmd head_cmd;    // oldest queued command
    logic          accept;
    logic          q_empty;
    logic          q_pop;

    // an item is taken whenever the queue has room
    assign accept = push && !full;

    // front tracks the triple position and precomputes the start value
    wsh_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_seed   (i_cfg_seed),
        .i_accept     (accept),
        .i_data_word  (i_data_word),
        .i_msg_length (i_msg_length),
        .i_first      (i_first),
        .i_last       (i_last),
        .o_cmd        (front_cmd)
    );

    // decouples the front, which takes one item per cycle while there is room, from the mixes
    wsh_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .o_full  (full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_cmd   (head_cmd)
    );

    // back holds the accumulators and the result register
    wsh_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_empty    (q_empty),
        .i_cmd        (head_cmd),
        .o_q_pop      (q_pop),
        .o_empty      (empty),
        .i_pop        (pop),
        .o_hash_value (o_hash_value)
    );

endmodule

`default_nettype wire

>>> bench/tb.sv
// self-checking bench for word_stream_hash_lookup3: directed and random messages
// checked against a lookup3 word-hash predictor held in a small scoreboard class
// depends on wsh_pkg and the rtl top level, nothing else
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CYCLE_LIMIT  = 200000;
    // drain time for the queued items and their mixes, queue holds 4 items
    localparam int unsigned DRAIN_CYCLES = 40;
    localparam int unsigned PHASE_ITEMS  = 80;

    // expected hashes, kept by running the hash on every accepted item
    class hash_scoreboard;
        logic [31:0]   seed_val;
        logic [31:0]   st_a;
        logic [31:0]   st_b;
        logic [31:0]   st_c;
        wsh_pkg::t_pos slot_next;
        logic [31:0]   pending_hashes[$];
        int            errors;

        function new();
            seed_val  = '0;
            st_a      = '0;
            st_b      = '0;
            st_c      = '0;
            slot_next = wsh_pkg::POS_A;
            errors    = 0;
        endfunction

        function void set_seed(logic [31:0] v);
            seed_val = v;
        endfunction

        function int pending();
            return pending_hashes.size();
        endfunction

        function logic [31:0] rol32(logic [31:0] v, int k);
            return (v << k) | (v >> (32 - k));
        endfunction

        // six-round mix of a completed triple
        function void stir_triple();
            logic [31:0] a;
            logic [31:0] b;
            logic [31:0] c;
            a = st_a; b = st_b; c = st_c;
            a = (a - c) ^ rol32(c, 4);  c = c + b;
            b = (b - a) ^ rol32(a, 6);  a = a + c;
            c = (c - b) ^ rol32(b, 8);  b = b + a;
            a = (a - c) ^ rol32(c, 16); c = c + b;
            b = (b - a) ^ rol32(a, 19); a = a + c;
            c = (c - b) ^ rol32(b, 4);  b = b + a;
            st_a = a; st_b = b; st_c = c;
        endfunction

        // closing mix applied on the last word
        function void close_triple();
            logic [31:0] a;
            logic [31:0] b;
            logic [31:0] c;
            a = st_a; b = st_b; c = st_c;
            c = (c ^ b) - rol32(b, 14);
            a = (a ^ c) - rol32(c, 11);
            b = (b ^ a) - rol32(a, 25);
            c = (c ^ b) - rol32(b, 16);
            a = (a ^ c) - rol32(c, 4);
            b = (b ^ a) - rol32(a, 14);
            c = (c ^ b) - rol32(b, 24);
            st_a = a; st_b = b; st_c = c;
        endfunction

        // one accepted input item
        function void note_item(logic [31:0] word, logic [15:0] len, logic first, logic last);
            logic [31:0]   start_val;
            logic          carries_word;
            wsh_pkg::t_pos slot;
            carries_word = 1'b1;
            if (first) begin
                start_val = wsh_pkg::HASH_INIT + {14'd0, len, 2'b00} + seed_val;
                st_a      = start_val;
                st_b      = start_val;
                st_c      = start_val;
                slot_next = wsh_pkg::POS_A;
                // zero length carries no word
                if (len == 16'd0) carries_word = 1'b0;
            end
            if (carries_word) begin
                slot = slot_next;
                case (slot)
                    wsh_pkg::POS_A: st_a = st_a + word;
                    wsh_pkg::POS_B: st_b = st_b + word;
                    default:        st_c = st_c + word;
                endcase
                if (last) begin
                    close_triple();
                end else if (slot == wsh_pkg::POS_C) begin
                    stir_triple();
                    slot_next = wsh_pkg::POS_A;
                end else begin
                    slot_next = (slot == wsh_pkg::POS_A) ? wsh_pkg::POS_B : wsh_pkg::POS_C;
                end
            end
            if (last) begin
                slot_next      = wsh_pkg::POS_A;
                pending_hashes = {pending_hashes, st_c};
            end
        endfunction

        task report(string msg);
            $display("[%0t] mismatch: %s", $realtime, msg);
            errors++;
        endtask

        task check_hash(logic [31:0] got);
            logic [31:0] want;
            if (pending_hashes.size() == 0) begin
                report($sformatf("hash_value %08h with no message pending", got));
            end else begin
                want = pending_hashes.pop_front();
                if (got !== want)
                    report($sformatf("hash_value got %08h, want %08h", got, want));
            end
        endtask
    endclass

    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic        i_cfg_we     = 1'b0;
    logic [31:0] i_cfg_seed   = '0;
    logic        push         = 1'b0;
    logic        full;
    logic [31:0] i_data_word  = '0;
    logic [15:0] i_msg_length = '0;
    logic        i_first      = 1'b0;
    logic        i_last       = 1'b0;
    logic        empty;
    logic        pop          = 1'b0;
    logic [31:0] o_hash_value;

    hash_scoreboard sb;
    int unsigned    cycle_count = 0;
    int             burst_left  = 0;
    bit             gaps_on     = 1'b1;
    int             rx_mode     = 1;

    word_stream_hash_lookup3 u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_seed   (i_cfg_seed),
        .push         (push),
        .full         (full),
        .i_data_word  (i_data_word),
        .i_msg_length (i_msg_length),
        .i_first      (i_first),
        .i_last       (i_last),
        .empty        (empty),
        .pop          (pop),
        .o_hash_value (o_hash_value)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // run limit; hitting it means the block hung or a hash never came out
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("FAILURE");
        $finish;
    end

    // mostly-random word, with the extremes mixed in
    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 15))
            0:       return 32'h0000_0000;
            1:       return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    // push one item; bursts of random length separated by random gaps when gaps are on
    task automatic send_item(input logic [31:0] w, input logic [15:0] len,
                             input logic f, input logic l);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap        = gaps_on ? $urandom_range(1, 6) : 0;
            repeat (gap) begin
                @(negedge i_clk);
                push <= 1'b0;
            end
        end
        burst_left--;
        @(negedge i_clk);
        push         <= 1'b1;
        i_data_word  <= w;
        i_msg_length <= len;
        i_first      <= f;
        i_last       <= l;
        // item taken at the first edge where full is low
        do @(posedge i_clk); while (full);
        sb.note_item(w, len, f, l);
    endtask

    // one well-formed message with random content; length field mostly honest
    task automatic send_message(output int n_items);
        int          n_words;
        logic [15:0] len;
        n_words = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 8);
        len     = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(0, 65535)) : 16'(n_words);
        if (n_words == 0) begin
            // empty message, or a one-word one if the length field disagrees
            send_item(pick_word(), len, 1'b1, 1'b1);
            n_items = 1;
        end else begin
            for (int i = 0; i < n_words; i++)
                send_item(pick_word(), len, i == 0, i == n_words - 1);
            n_items = n_words;
        end
    endtask

    // broken sequences: random flags, random length bits
    task automatic send_noise(output int n_items);
        n_items = $urandom_range(1, 3);
        repeat (n_items)
            send_item($urandom, 16'($urandom_range(0, 65535)),
                      1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    endtask

    // drop push, let every hash come out, then let a trailing partial
    // message finish inside the back end
    task automatic wait_idle();
        @(negedge i_clk);
        push <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_seed(input logic [31:0] v);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_seed <= v;
        @(posedge i_clk);
        sb.set_seed(v);
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    // result side: stall pattern chosen per phase
    //   mode 0 always ready, mode 1 random 70 percent, mode 2 long stall runs
    initial begin
        int stall_left;
        stall_left = 0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                pop <= 1'b0;
                stall_left--;
            end else begin
                case (rx_mode)
                    0: pop <= 1'b1;
                    1: pop <= ($urandom_range(0, 9) < 7);
                    default: begin
                        if ($urandom_range(0, 7) == 0) begin
                            stall_left = $urandom_range(5, 30);
                            pop <= 1'b0;
                        end else begin
                            pop <= 1'b1;
                        end
                    end
                endcase
            end
            @(posedge i_clk);
            if (pop && !empty) sb.check_hash(o_hash_value);
        end
    end

    initial begin
        int          sent;
        int          n;
        logic [31:0] phase_seed;
        sb = new();

        // synchronous reset
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        write_seed(32'h0000_0000);

        // words with no start right after reset run on the cleared accumulators
        send_item(32'hffff_ffff, 16'h0000, 1'b0, 1'b0);
        send_item(32'h0000_0001, 16'hffff, 1'b0, 1'b1);
        // empty message: initial c, word ignored
        send_item(32'hffff_ffff, 16'd0, 1'b1, 1'b1);
        // single word, first and last together
        send_item(32'h0000_0000, 16'd1, 1'b1, 1'b1);
        // three words: last lands in c, no triple mix before the final one
        send_item(32'h0123_4567, 16'd3, 1'b1, 1'b0);
        send_item(32'h89ab_cdef, 16'd3, 1'b0, 1'b0);
        send_item(32'hfedc_ba98, 16'd3, 1'b0, 1'b1);
        // four words: one triple mix, then last lands in a
        send_item(32'hffff_ffff, 16'd4, 1'b1, 1'b0);
        repeat (2) send_item(32'hffff_ffff, 16'd4, 1'b0, 1'b0);
        send_item(32'hffff_ffff, 16'd4, 1'b0, 1'b1);
        wait_idle();
        write_seed(32'hffff_ffff);

        // zero length start without last, words follow anyway
        send_item(32'hdead_beef, 16'd0, 1'b1, 1'b0);
        send_item(32'h0000_0005, 16'd0, 1'b0, 1'b1);
        // length field far off from the words delivered
        send_item(32'ha5a5_a5a5, 16'hffff, 1'b1, 1'b0);
        send_item(32'h5a5a_5a5a, 16'hffff, 1'b0, 1'b1);
        // words after a last with no new start
        send_item(32'h1234_5678, 16'd0, 1'b0, 1'b0);
        send_item(32'h0000_0000, 16'd0, 1'b0, 1'b1);
        // restart in the middle of a message
        send_item(32'h0000_0001, 16'd5, 1'b1, 1'b0);
        send_item(32'h0000_0002, 16'd5, 1'b0, 1'b0);
        send_item(32'h0000_0003, 16'd2, 1'b1, 1'b0);
        send_item(32'h0000_0004, 16'd2, 1'b0, 1'b1);
        // five words: triple mix, then last lands in b
        send_item(32'hffff_ffff, 16'd5, 1'b1, 1'b0);
        send_item(32'h0000_0000, 16'd5, 1'b0, 1'b0);
        send_item(32'hffff_ffff, 16'd5, 1'b0, 1'b0);
        send_item(32'h0000_0000, 16'd5, 1'b0, 1'b0);
        send_item(32'h8000_0001, 16'd5, 1'b0, 1'b1);
        wait_idle();

        // random phases, each with its own seed, sender gap setting and receiver stall mode
        for (int p = 0; p < 6; p++) begin
            case (p)
                0:       phase_seed = 32'h0000_0001;
                2:       phase_seed = 32'h8000_0000;
                4:       phase_seed = 32'hffff_ffff;
                5:       phase_seed = 32'h0000_0000;
                default: phase_seed = $urandom;
            endcase
            write_seed(phase_seed);
            rx_mode = p % 3;
            gaps_on = (p % 2 == 0);
            sent    = 0;
            while (sent < PHASE_ITEMS) begin
                if ($urandom_range(0, 9) == 0) send_noise(n);
                else                           send_message(n);
                sent += n;
            end
            wait_idle();
        end

        if (sb.errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

`default_nettype wire
